/* design/srptp_pkg.sv */
// Shared types and constants of the stepper ramp pulse timing block.
// Used by the front, back and top modules of the block; no dependencies of its own.
`timescale 1ns / 1ps

package srptp_pkg;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CNT_MAX       = 16'hFFFF;
    localparam logic [15:0] LOW_TIME_RST  = 16'd100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_STEPS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIP_DEPTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIP_HOLD     = 3'd4;

    // operation codes on the request side
    typedef enum logic [2:0] {
        OP_TIMER  = 3'd0,
        OP_START  = 3'd1,
        OP_SMOOTH = 3'd2,
        OP_STOP   = 3'd3,
        OP_ESTOP  = 3'd4,
        OP_TWRITE = 3'd5
    } op_t;

    // classified command kinds handed from front to back
    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_TIMER,
        KIND_START,
        KIND_SMOOTH,
        KIND_STOP,
        KIND_ESTOP,
        KIND_TWRITE
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] adjustment;
        logic [7:0]  table_index;
        logic [15:0] table_value;
    } cmd_t;

    typedef struct packed {
        logic [15:0] low_time;
        logic [15:0] target_steps;
        logic [7:0]  ramp_limit;
        logic [7:0]  dip_depth;
        logic [15:0] dip_hold;
    } cfg_t;

    typedef struct packed {
        logic        pulse_level;
        logic [15:0] period;
        logic [7:0]  ramp_index;
        logic [15:0] steps_done;
        logic        move_done;
        logic        smooth_active;
    } res_t;

endpackage

/* design/srptp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module srptp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/srptp_front.sv */
// Front part: decode requests into commands and hold them in a short queue.
// Depends on srptp_pkg.
`timescale 1ns / 1ps

module srptp_front #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        operation,
    input  logic [15:0]       adjustment,
    input  logic [7:0]        table_index,
    input  logic [15:0]       table_value,
    output logic              q_valid,
    output srptp_pkg::cmd_t   q_cmd,
    input  logic              q_pop
);

    srptp_pkg::cmd_t                    cmd;
    srptp_pkg::cmd_t                    q_mem_reg [srptp_pkg::QUEUE_DEPTH];
    logic [srptp_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [srptp_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [srptp_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    logic                               push;

    // classify; table writes out of range become no-ops
    always_comb
    begin
        cmd.adjustment  = adjustment;
        cmd.table_index = table_index;
        cmd.table_value = table_value;
        case (operation)
            srptp_pkg::OP_TIMER:  cmd.kind = srptp_pkg::KIND_TIMER;
            srptp_pkg::OP_START:  cmd.kind = srptp_pkg::KIND_START;
            srptp_pkg::OP_SMOOTH: cmd.kind = srptp_pkg::KIND_SMOOTH;
            srptp_pkg::OP_STOP:   cmd.kind = srptp_pkg::KIND_STOP;
            srptp_pkg::OP_ESTOP:  cmd.kind = srptp_pkg::KIND_ESTOP;
            srptp_pkg::OP_TWRITE:
            begin
                if (32'(table_index) < TABLE_DEPTH)
                    cmd.kind = srptp_pkg::KIND_TWRITE;
                else
                    cmd.kind = srptp_pkg::KIND_NOP;
            end
            default: cmd.kind = srptp_pkg::KIND_NOP;
        endcase
    end

    assign in_ready = (cnt_reg != srptp_pkg::QCNT_W'(srptp_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            if (wr_ptr_reg == srptp_pkg::QPTR_W'(srptp_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            if (rd_ptr_reg == srptp_pkg::QPTR_W'(srptp_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && q_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

/* design/srptp_back.sv */
// Back part: execute commands against the motion state and the interval table.
// Depends on srptp_pkg and srptp_ram.
`timescale 1ns / 1ps

module srptp_back #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  srptp_pkg::cfg_t   cfg,
    input  logic              q_valid,
    input  srptp_pkg::cmd_t   q_cmd,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output srptp_pkg::res_t   res
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic signed [19:0] IDX_MAX = 20'(TABLE_DEPTH - 1);

    // motion state
    logic               phase_reg, phase_next;
    logic [15:0]        sc_reg, sc_next;
    logic [15:0]        pk_reg, pk_next;
    logic [15:0]        ds_reg, ds_next;
    logic [15:0]        ml_reg, ml_next;
    logic [15:0]        dc_reg, dc_next;
    logic               en_reg, en_next;
    logic signed [16:0] floor_reg, floor_next;

    // result register
    logic               vld_reg;
    logic               level_reg, level_next;
    logic               use_tab_reg, use_tab_next;
    logic [15:0]        pre_reg, pre_next;
    logic [7:0]         ridx_reg, ridx_next;
    logic [15:0]        steps_reg;
    logic               mdone_reg;
    logic               smooth_reg;

    logic               go;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [15:0]        ram_rdata;

    // ramp index selection
    logic [16:0]        hold_end;
    logic [17:0]        dip_end;
    logic signed [19:0] sc_s, pk_s, dc_s, ml_s, he_s, fl_s, idx, idx_sat;
    logic [15:0]        dc_inc;
    logic [15:0]        pk_start, pk_force;

    assign go    = q_valid && (!vld_reg || out_ready);
    assign q_pop = go;

    assign hold_end = {9'd0, cfg.dip_depth} + {1'b0, cfg.dip_hold};
    assign dip_end  = {1'b0, hold_end} + {10'd0, cfg.dip_depth};
    assign sc_s     = $signed({4'd0, sc_reg});
    assign pk_s     = $signed({4'd0, pk_reg});
    assign dc_s     = $signed({4'd0, dc_reg});
    assign ml_s     = $signed({4'd0, ml_reg});
    assign he_s     = $signed({3'd0, hold_end});
    assign fl_s     = {{3{floor_reg[16]}}, floor_reg};
    assign dc_inc   = (dc_reg != srptp_pkg::CNT_MAX) ? dc_reg + 16'd1 : dc_reg;

    always_comb
    begin
        idx = '0;
        if (sc_reg <= pk_reg)
            idx = sc_s;
        else if (sc_reg < ds_reg)
        begin
            if (!en_reg)
                idx = pk_s;
            else if (fl_s < pk_s - dc_s)
                idx = pk_s - dc_s;
            else if (dc_s < he_s)
                idx = fl_s;
            else if ({2'd0, dc_reg} < dip_end)
                idx = fl_s + (dc_s - he_s);
            else
                idx = '0;
        end
        else if (ml_reg >= sc_reg)
            idx = ml_s - sc_s;
        if (idx < 0)
            idx_sat = '0;
        else if (idx > IDX_MAX)
            idx_sat = IDX_MAX;
        else
            idx_sat = idx;
    end

    assign ram_raddr = AW'(idx_sat);

    assign pk_start = ({1'b0, cfg.target_steps} <= {8'd0, cfg.ramp_limit, 1'b0})
                      ? {1'b0, cfg.target_steps[15:1]} : {8'd0, cfg.ramp_limit};
    assign pk_force = (q_cmd.kind == srptp_pkg::KIND_ESTOP) ? {1'b0, pk_reg[15:1]} : pk_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        sc_next      = sc_reg;
        pk_next      = pk_reg;
        ds_next      = ds_reg;
        ml_next      = ml_reg;
        dc_next      = dc_reg;
        en_next      = en_reg;
        floor_next   = floor_reg;
        level_next   = 1'b0;
        use_tab_next = 1'b0;
        pre_next     = '0;
        ridx_next    = '0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        if (go)
        begin
            case (q_cmd.kind)
                srptp_pkg::KIND_TIMER:
                begin
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        pre_next   = cfg.low_time;
                    end
                    else
                    begin
                        phase_next   = 1'b0;
                        level_next   = 1'b1;
                        use_tab_next = 1'b1;
                        ram_re       = 1'b1;
                        pre_next     = q_cmd.adjustment - cfg.low_time;
                        ridx_next    = (idx_sat > 20'sd255) ? 8'hFF : idx_sat[7:0];
                        if (sc_reg != srptp_pkg::CNT_MAX)
                            sc_next = sc_reg + 16'd1;
                        // the dip advances only in the constant-speed run
                        if (sc_reg > pk_reg && sc_reg < ds_reg && en_reg)
                        begin
                            dc_next = dc_inc;
                            if ({2'd0, dc_inc} >= dip_end)
                                en_next = 1'b0;
                        end
                    end
                end
                srptp_pkg::KIND_START:
                begin
                    ml_next = cfg.target_steps;
                    pk_next = pk_start;
                    ds_next = cfg.target_steps - pk_start;
                    sc_next = '0;
                end
                srptp_pkg::KIND_SMOOTH:
                begin
                    floor_next = $signed({1'b0, pk_reg}) - $signed({9'd0, cfg.dip_depth});
                    dc_next    = '0;
                    en_next    = (({9'd0, cfg.dip_depth} << 1) + {1'b0, cfg.dip_hold}) != '0;
                end
                srptp_pkg::KIND_STOP, srptp_pkg::KIND_ESTOP:
                begin
                    pk_next = pk_force;
                    sc_next = pk_force;
                    ds_next = pk_force;
                    ml_next = {pk_force[14:0], 1'b0};
                end
                srptp_pkg::KIND_TWRITE:
                begin
                    ram_we = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    srptp_ram #(
        .WIDTH(16),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(AW'(q_cmd.table_index)),
        .wdata(q_cmd.table_value),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            sc_reg    <= '0;
            pk_reg    <= '0;
            ds_reg    <= '0;
            ml_reg    <= '0;
            dc_reg    <= '0;
            en_reg    <= 1'b0;
            floor_reg <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            sc_reg    <= sc_next;
            pk_reg    <= pk_next;
            ds_reg    <= ds_next;
            ml_reg    <= ml_next;
            dc_reg    <= dc_next;
            en_reg    <= en_next;
            floor_reg <= floor_next;
            if (go)
                vld_reg <= 1'b1;
            else if (out_ready)
                vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            level_reg   <= level_next;
            use_tab_reg <= use_tab_next;
            pre_reg     <= pre_next;
            ridx_reg    <= ridx_next;
            steps_reg   <= sc_next;
            mdone_reg   <= sc_next > ml_next;
            smooth_reg  <= en_next;
        end
    end

    assign out_valid         = vld_reg;
    assign res.pulse_level   = level_reg;
    assign res.period        = use_tab_reg ? ram_rdata + pre_reg : pre_reg;
    assign res.ramp_index    = ridx_reg;
    assign res.steps_done    = steps_reg;
    assign res.move_done     = mdone_reg;
    assign res.smooth_active = smooth_reg;

endmodule

/* design/stepper_ramp_pulse_timing.sv */
// Top level of the stepper ramp pulse timing block: config registers,
// front/back split. Depends on srptp_pkg, srptp_front, srptp_back, srptp_ram.
`timescale 1ns / 1ps

// Step-pulse timing for one stepper motor. Each request on the slave stream
// carries an operation in s_tuser (timer event, start move, smooth turn, stop,
// emergency stop, table write) and returns exactly one result on the master
// stream, in request order. A timer event alternates low and high pulse
// phases; a high phase reads the interval table at the current ramp index
// and reports the period minus low_time plus the request's adjustment, mod
// 2^16. The block sustains one request per clock while the master takes every
// result: a two-entry queue parts the decode front from the execute back, the
// back updates the motion state and issues its single table read in the same
// cycle, and the result sits in an output register so a stalled master does
// not stop the queue filling; each result waits in that output register. The
// interval table holds TABLE_DEPTH entries and must be written (operation 5)
// before any entry is read. Configuration writes are always taken
// (cfg_ready is high) and must only happen while no request is in flight.
module stepper_ramp_pulse_timing #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // adjustment[15:0], table_index[23:16], table_value[39:24]
    input  logic [srptp_pkg::IN_TDATA_W-1:0]    s_tdata,
    // operation[2:0]
    input  logic [srptp_pkg::IN_TUSER_W-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pulse_level[0], period[16:1], ramp_index[24:17], steps_done[40:25],
    // move_done[41], smooth_active[42], zero fill[47:43]
    output logic [srptp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [srptp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srptp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    srptp_pkg::cfg_t cfg_reg;
    srptp_pkg::cmd_t q_cmd;
    srptp_pkg::res_t res;
    logic            q_valid;
    logic            q_pop;

    // Hold the config registers; indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_time     <= srptp_pkg::LOW_TIME_RST;
            cfg_reg.target_steps <= '0;
            cfg_reg.ramp_limit   <= '0;
            cfg_reg.dip_depth    <= '0;
            cfg_reg.dip_hold     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                srptp_pkg::REG_LOW_TIME:     cfg_reg.low_time     <= cfg_data;
                srptp_pkg::REG_TARGET_STEPS: cfg_reg.target_steps <= cfg_data;
                srptp_pkg::REG_RAMP_LIMIT:   cfg_reg.ramp_limit   <= cfg_data[7:0];
                srptp_pkg::REG_DIP_DEPTH:    cfg_reg.dip_depth    <= cfg_data[7:0];
                srptp_pkg::REG_DIP_HOLD:     cfg_reg.dip_hold     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Decode each request and queue it.
    srptp_front #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .operation  (s_tuser[2:0]),
        .adjustment (s_tdata[15:0]),
        .table_index(s_tdata[23:16]),
        .table_value(s_tdata[39:24]),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop)
    );

    // Execute queued commands and register the result.
    srptp_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .res      (res)
    );

    // Pack the result, lowest field first.
    assign m_tdata = {5'd0, res.smooth_active, res.move_done, res.steps_done,
                      res.ramp_index, res.period, res.pulse_level};

    // A new result only appears after a command left the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(q_pop))
        else $error("result valid without a queued command");

    // A full queue must have something to hand to the back.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_valid)
        else $error("queue refuses requests while empty");

    // Only a high phase reports a ramp index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !res.pulse_level) |-> (res.ramp_index == 8'd0))
        else $error("ramp index reported outside a high phase");

    // A pop needs a valid queue head.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command taken from an empty queue");

endmodule

/* bench/tb.sv */
// Self-checking bench for stepper_ramp_pulse_timing: stream requests in,
// predicted pulse timing checked against every result. Needs srptp_pkg and
// the block's RTL only.
`timescale 1ns / 1ps

module tb;

    import srptp_pkg::*;

    localparam int QUIET_LIMIT = 4000;  // cycles with no handshake at all
    localparam int TAIL_CYCLES = 20;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 60;

    // Scoreboard: a private copy of the timing state predicts the result of
    // each accepted request and holds it until the block returns one.
    class pulse_scoreboard;

        logic [15:0] cfg_low;
        logic [15:0] cfg_target;
        logic [7:0]  cfg_limit;
        logic [7:0]  cfg_depth;
        logic [15:0] cfg_hold;

        logic        drive_high;
        logic [15:0] step_cnt;
        logic [15:0] peak;
        logic [15:0] decel_at;
        logic [15:0] move_len;
        logic [15:0] dip_cnt;
        logic        dip_on;
        int          dip_base;
        logic [15:0] intervals [256];

        res_t        timing_q [$];
        int          errors;
        int          seen;

        function new();
            cfg_low    = LOW_TIME_RST;
            cfg_target = '0;
            cfg_limit  = '0;
            cfg_depth  = '0;
            cfg_hold   = '0;
            drive_high = 1'b0;
            step_cnt   = '0;
            peak       = '0;
            decel_at   = '0;
            move_len   = '0;
            dip_cnt    = '0;
            dip_on     = 1'b0;
            dip_base   = 0;
            errors     = 0;
            seen       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                REG_LOW_TIME:     cfg_low    = val;
                REG_TARGET_STEPS: cfg_target = val;
                REG_RAMP_LIMIT:   cfg_limit  = val[7:0];
                REG_DIP_DEPTH:    cfg_depth  = val[7:0];
                REG_DIP_HOLD:     cfg_hold   = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return timing_q.size();
        endfunction

        // Ramp index of a high phase; advances the smooth-turn dip as a side effect.
        function int next_ramp_index();
            int sc;
            int pk;
            int dc;
            int hold_end;
            int dip_end;
            int idx;
            sc  = step_cnt;
            pk  = peak;
            idx = 0;
            if (sc <= pk)
            begin
                idx = sc;
            end
            else if (sc < int'(decel_at))
            begin
                if (!dip_on)
                begin
                    idx = pk;
                end
                else
                begin
                    dc       = dip_cnt;
                    hold_end = int'(cfg_depth) + int'(cfg_hold);
                    dip_end  = hold_end + int'(cfg_depth);
                    if (dip_base < pk - dc)
                        idx = pk - dc;
                    else if (dc < hold_end)
                        idx = dip_base;
                    else if (dc < dip_end)
                        idx = dip_base + (dc - hold_end);
                    else
                        idx = 0;    // profile ran past its end while still enabled
                    if (dip_cnt != CNT_MAX)
                        dip_cnt++;
                    if (int'(dip_cnt) >= dip_end)
                        dip_on = 1'b0;
                end
            end
            else
            begin
                if (move_len >= step_cnt)
                    idx = int'(move_len) - sc;
                else
                    idx = 0;
            end
            if (idx < 0)
                idx = 0;
            if (idx > 255)
                idx = 255;
            return idx;
        endfunction

        // Jump straight into deceleration from the current peak.
        function void enter_decel();
            step_cnt = peak;
            decel_at = peak;
            move_len = peak << 1;
        endfunction

        function void take_request(logic [2:0] op, logic [15:0] adj,
                                   logic [7:0] tidx, logic [15:0] tval);
            res_t r;
            int   idx;
            r = '0;
            case (op)
                OP_TIMER:
                begin
                    if (!drive_high)
                    begin
                        drive_high = 1'b1;
                        r.period   = cfg_low;
                    end
                    else
                    begin
                        drive_high    = 1'b0;
                        r.pulse_level = 1'b1;
                        idx           = next_ramp_index();
                        r.period      = intervals[idx] - cfg_low + adj;
                        r.ramp_index  = idx[7:0];
                        if (step_cnt != CNT_MAX)
                            step_cnt++;
                    end
                end
                OP_START:
                begin
                    move_len = cfg_target;
                    if (int'(cfg_target) <= 2 * int'(cfg_limit))
                        peak = cfg_target >> 1;
                    else
                        peak = {8'd0, cfg_limit};
                    decel_at = cfg_target - peak;
                    step_cnt = '0;
                end
                OP_SMOOTH:
                begin
                    dip_base = int'(peak) - int'(cfg_depth);
                    dip_cnt  = '0;
                    dip_on   = (2 * int'(cfg_depth) + int'(cfg_hold)) != 0;
                end
                OP_STOP:
                    enter_decel();
                OP_ESTOP:
                begin
                    peak = peak >> 1;
                    enter_decel();
                end
                OP_TWRITE:
                    intervals[tidx] = tval;
                default: ;
            endcase
            r.steps_done    = step_cnt;
            r.move_done     = step_cnt > move_len;
            r.smooth_active = dip_on;
            timing_q.push_back(r);
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            $display("MISMATCH result %0d %s: got %0h expected %0h", seen, what, got, want);
            errors++;
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] word);
            res_t want;
            seen++;
            if (timing_q.size() == 0)
            begin
                report("no request waiting", word[15:0], 16'h0);
                return;
            end
            want = timing_q.pop_front();
            if (word[0] !== want.pulse_level)
                report("pulse_level", word[0], want.pulse_level);
            if (word[16:1] !== want.period)
                report("period", word[16:1], want.period);
            if (word[24:17] !== want.ramp_index)
                report("ramp_index", word[24:17], want.ramp_index);
            if (word[40:25] !== want.steps_done)
                report("steps_done", word[40:25], want.steps_done);
            if (word[41] !== want.move_done)
                report("move_done", word[41], want.move_done);
            if (word[42] !== want.smooth_active)
                report("smooth_active", word[42], want.smooth_active);
            if (word[47:43] !== 5'd0)
                report("fill bits", word[47:43], 16'h0);
        endtask

    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;   // adjustment, table_index, table_value from bit 0
    logic [IN_TUSER_W-1:0]   s_tuser;   // operation
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    pulse_scoreboard sb;
    logic            idle_on;       // random idling on both streams
    int              quiet_cycles;

    stepper_ramp_pulse_timing dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Offer one request; hold it until the block takes it, then predict its result.
    task automatic send_request(input logic [2:0] op, input logic [15:0] adj,
                                input logic [7:0] tidx, input logic [15:0] tval);
        @(negedge clk);
        while (idle_on && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tval, tidx, adj};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        sb.take_request(op, adj, tidx, tval);
    endtask

    // Timer events with random adjustment; the other fields are don't-care.
    task automatic tick(input int n);
        for (int i = 0; i < n; i++)
            send_request(OP_TIMER, 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    endtask

    // Drop valid and hold off until every predicted result has come back.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write all five registers; only call with the block drained.
    task automatic set_all(input logic [15:0] low, input logic [15:0] target,
                           input logic [7:0] limit, input logic [7:0] depth,
                           input logic [15:0] hold);
        set_reg(REG_LOW_TIME, low);
        set_reg(REG_TARGET_STEPS, target);
        set_reg(REG_RAMP_LIMIT, {8'd0, limit});
        set_reg(REG_DIP_DEPTH, {8'd0, depth});
        set_reg(REG_DIP_HOLD, hold);
    endtask

    // Register value: mostly small so ramps finish quickly, sometimes an extreme.
    function automatic logic [15:0] pick_reg(input int top, input int small_top);
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'(top);
            5:       return 16'($urandom_range(0, top));
            default: return 16'($urandom_range(0, small_top));
        endcase
    endfunction

    // Result side: random backpressure, check everything accepted.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= !(idle_on && $urandom_range(0, 99) < 36);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog: give up when nothing at all moves for too long.
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int          roll;
        logic [2:0]  op;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_on   = 1'b1;
        sb        = new();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Fill the whole interval table first so no read ever hits an unwritten entry.
        for (int i = 0; i < 256; i++)
            send_request(OP_TWRITE, 16'($urandom_range(0, 65535)), 8'(i),
                         (i == 0) ? 16'h0000 :
                         (i == 255) ? 16'hFFFF : 16'($urandom_range(0, 65535)));

        // Directed: short trapezoid with a smooth turn, stops, unused codes.
        drain();
        set_all(16'd0, 16'd12, 8'd3, 8'd1, 16'd2);
        send_request(OP_TIMER, 16'hFFFF, 8'h00, 16'h0000);    // low phase before any move
        send_request(OP_TIMER, 16'h0000, 8'h00, 16'h0000);    // high phase, accelerate from zero
        send_request(OP_START, 16'hFFFF, 8'hFF, 16'hFFFF);
        tick(8);
        send_request(OP_SMOOTH, 16'h0000, 8'h00, 16'h0000);
        tick(8);                                             // dip down, hold, recover, clear
        send_request(OP_TWRITE, 16'hFFFF, 8'hFF, 16'h0000);
        send_request(3'd6, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_request(3'd7, 16'h0000, 8'h00, 16'h0000);
        send_request(OP_STOP, 16'h1234, 8'h5A, 16'hA5A5);
        tick(2);
        send_request(OP_ESTOP, 16'h0000, 8'h00, 16'h0000);

        // Long run without idling: a move with a long constant-speed run and a
        // smooth turn, then shrink the dip so its profile runs out while enabled.
        drain();
        idle_on = 1'b0;
        set_all(16'($urandom_range(0, 65535)), 16'd400, 8'd5, 8'd3, 16'd20);
        send_request(OP_START, 16'h0000, 8'h00, 16'h0000);
        tick(40);
        send_request(OP_SMOOTH, 16'h0000, 8'h00, 16'h0000);
        tick(6);                                             // dip partway down
        drain();
        set_reg(REG_DIP_DEPTH, 16'd0);
        set_reg(REG_DIP_HOLD, 16'd0);
        tick(4);                                             // profile exhausted, dip clears
        tick(60);
        drain();
        idle_on = 1'b1;

        // Random phases: fresh settings per phase, one move of mostly timer events.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            if (ph == 0)
                set_all(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
            else if (ph == 1)
                set_all(16'd0, 16'd0, 8'd0, 8'd0, 16'd0);
            else
                set_all(pick_reg(65535, 300), pick_reg(65535, 80), 8'(pick_reg(255, 40)),
                        8'(pick_reg(255, 10)), pick_reg(65535, 20));
            send_request(OP_START, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 65535)));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 74)
                    op = OP_TIMER;
                else if (roll < 79)
                    op = OP_SMOOTH;
                else if (roll < 83)
                    op = OP_STOP;
                else if (roll < 86)
                    op = OP_ESTOP;
                else if (roll < 91)
                    op = OP_TWRITE;
                else if (roll < 95)
                    op = OP_START;
                else if (roll < 97)
                    op = 3'($urandom_range(6, 7));
                else
                    op = 3'($urandom_range(0, 7));
                send_request(op, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                             16'($urandom_range(0, 65535)));
            end
        end

        // Wait out the last results, then a short tail to catch strays.
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
